// ===== rtl/pbwt_pkg.sv =====
// ----------------------------------------------------------------------------
// pbwt_pkg
// shared constants, types and state codes of the long match reporter
// ----------------------------------------------------------------------------
package pbwt_pkg;

  localparam int HAPLOTYPES    = 64;
  localparam int SITE_BITS     = 16;

  localparam int HAP_BITS      = $clog2(HAPLOTYPES);
  localparam int CNT_BITS      = $clog2(HAPLOTYPES + 1);
  localparam int ENTRY_BITS    = HAP_BITS + SITE_BITS;
  localparam int RAM_DEPTH     = 4 * HAPLOTYPES;
  localparam int RAM_ADDR_BITS = HAP_BITS + 2;
  localparam int CMP_BITS      = ((SITE_BITS > 16) ? SITE_BITS : 16) + 1;

  localparam logic [SITE_BITS-1:0] SITE_END  = {SITE_BITS{1'b1}};
  localparam logic [15:0]          MML_RESET = 16'd4;

  // list select inside one bank
  localparam logic LIST_ZERO = 1'b0;
  localparam logic LIST_ONE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_CLOSE,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [SITE_BITS-1:0]  site;
    logic [HAPLOTYPES-1:0] zero_mask;
    logic [HAPLOTYPES-1:0] one_mask;
    logic                  last;
  } result_t;

endpackage

// ===== rtl/pbwt_ram.sv =====
// ----------------------------------------------------------------------------
// pbwt_ram
// simple dual-port ram, one write port, one registered read port with enable
// ----------------------------------------------------------------------------
module pbwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pbwt_long_match_reporter.sv =====
// ----------------------------------------------------------------------------
// pbwt_long_match_reporter
// positional bwt update with long match group reporting, one site per item
// ----------------------------------------------------------------------------
// order of work for a site: after acceptance the walk issues ram reads and processes
//   one entry per cycle while reports do not stall, then close, then flush
// a new site is taken only in idle, after the flush of the previous one
// an ignored column (site range used up) is accepted in idle without a walk
// reset: order reads as identity, divergence as zero, site count zero,
//   min_match_length 4; no clearing pass, a fresh flag masks the ram
// ----------------------------------------------------------------------------
module pbwt_long_match_reporter
  import pbwt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] alleles,
  input  logic        restart,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] site,
  output logic [63:0] zero_group,
  output logic [63:0] one_group,
  output logic        last
);

  // state machine
  state_t state, state_next;

  // configuration and panel state
  logic [15:0]           min_match_length;
  logic [SITE_BITS-1:0]  site_count;
  logic                  fresh;       // panel at reset values, ram ignored
  logic                  rbank;       // bank holding the current order
  logic [CNT_BITS-1:0]   nz_saved;    // zero list length in the read bank

  // per site working registers
  logic [63:0]           col;
  logic [SITE_BITS-1:0]  site_cur;
  logic [CNT_BITS-1:0]   rd_idx;
  logic [CNT_BITS-1:0]   proc_idx;
  logic                  proc_valid;
  logic [CNT_BITS-1:0]   nz_cnt;
  logic [CNT_BITS-1:0]   no_cnt;
  logic [SITE_BITS-1:0]  p_div;
  logic [SITE_BITS-1:0]  q_div;
  logic [HAPLOTYPES-1:0] zm;
  logic [HAPLOTYPES-1:0] om;

  // report staging: pend waits until we know whether it is the last one
  result_t               pend;
  logic                  pend_valid;
  result_t               out_r;

  // ram ports
  logic                     ram_we, ram_re;
  logic [RAM_ADDR_BITS-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_BITS-1:0]    ram_wdata, ram_rdata;

  // walk datapath
  logic [HAP_BITS-1:0]   entry_h;
  logic [SITE_BITS-1:0]  entry_m;
  logic [HAPLOTYPES-1:0] entry_bit;
  logic                  entry_allele;
  logic                  brk;
  logic                  both;
  logic                  emit;
  logic                  flush;
  logic                  out_free;
  logic                  out_load;
  logic                  advance;
  logic [SITE_BITS-1:0]  p_max, q_max;
  logic                  rd_zero_list;
  logic [CNT_BITS-1:0]   rd_one_idx;
  logic                  accept;
  logic                  take_site;

  pbwt_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entry under processing: identity order and zero divergence while fresh
  always_comb begin
    entry_h      = fresh ? proc_idx[HAP_BITS-1:0] : ram_rdata[ENTRY_BITS-1 -: HAP_BITS];
    entry_m      = fresh ? '0 : ram_rdata[SITE_BITS-1:0];
    entry_bit    = {{(HAPLOTYPES-1){1'b0}}, 1'b1} << entry_h;
    entry_allele = col[entry_h];
    // divergence > site - length, done as m + length > site without sign
    brk          = (CMP_BITS'(entry_m) + CMP_BITS'(min_match_length)) > CMP_BITS'(site_cur);
    both         = (|zm) && (|om);
    p_max        = (entry_m > p_div) ? entry_m : p_div;
    q_max        = (entry_m > q_div) ? entry_m : q_div;
  end

  // report handshake and stall
  always_comb begin
    out_free = !out_valid || out_ready;
    emit     = ((state == ST_WALK) && proc_valid && brk && both) ||
               ((state == ST_CLOSE) && both);
    flush    = (state == ST_FLUSH) && pend_valid;
    // moving pend into the output register needs that register free
    advance  = !(((emit && pend_valid) || flush) && !out_free);
    out_load = ((emit && pend_valid) || flush) && advance;
  end

  // ram addressing: read bank holds zero list then one list of the last site
  always_comb begin
    rd_zero_list = rd_idx < nz_saved;
    rd_one_idx   = rd_idx - nz_saved;
    ram_re       = (state == ST_WALK) && advance && (rd_idx < CNT_BITS'(HAPLOTYPES));
    ram_raddr    = rd_zero_list ? {rbank, LIST_ZERO, rd_idx[HAP_BITS-1:0]}
                                : {rbank, LIST_ONE, rd_one_idx[HAP_BITS-1:0]};
    ram_we       = (state == ST_WALK) && proc_valid && advance;
    if (entry_allele) begin
      ram_waddr = {~rbank, LIST_ONE, no_cnt[HAP_BITS-1:0]};
      ram_wdata = {entry_h, q_max};
    end else begin
      ram_waddr = {~rbank, LIST_ZERO, nz_cnt[HAP_BITS-1:0]};
      ram_wdata = {entry_h, p_max};
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && (restart || (site_count != SITE_END))) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (proc_valid && advance && (proc_idx == CNT_BITS'(HAPLOTYPES - 1))) begin
          state_next = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (advance) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (advance) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  assign accept    = in_valid && in_ready;
  assign take_site = accept && (restart || (site_count != SITE_END));

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      min_match_length <= MML_RESET;
      site_count       <= '0;
      fresh            <= 1'b1;
      rbank            <= 1'b0;
      nz_saved         <= '0;
      proc_valid       <= 1'b0;
      pend_valid       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        min_match_length <= cfg_data;
      end

      // output register: loaded from pend, emptied when the item is taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // start of a site
      if (take_site) begin
        col        <= alleles;
        site_cur   <= restart ? '0 : site_count;
        p_div      <= restart ? SITE_BITS'(1) : site_count + SITE_BITS'(1);
        q_div      <= restart ? SITE_BITS'(1) : site_count + SITE_BITS'(1);
        rd_idx     <= '0;
        proc_idx   <= '0;
        proc_valid <= 1'b0;
        nz_cnt     <= '0;
        no_cnt     <= '0;
        zm         <= '0;
        om         <= '0;
        if (restart) begin
          fresh <= 1'b1;
        end
      end

      // walk: one read issued and one entry processed per cycle while advance holds
      if ((state == ST_WALK) && advance) begin
        proc_valid <= ram_re;
        if (ram_re) begin
          rd_idx <= rd_idx + CNT_BITS'(1);
        end
        if (proc_valid) begin
          proc_idx <= proc_idx + CNT_BITS'(1);
          if (entry_allele) begin
            no_cnt <= no_cnt + CNT_BITS'(1);
            q_div  <= '0;
            p_div  <= p_max;
            om     <= (brk ? '0 : om) | entry_bit;
            zm     <= brk ? '0 : zm;
          end else begin
            nz_cnt <= nz_cnt + CNT_BITS'(1);
            p_div  <= '0;
            q_div  <= q_max;
            zm     <= (brk ? '0 : zm) | entry_bit;
            om     <= brk ? '0 : om;
          end
        end
      end

      // a closed group with both alleles: older pending report goes out
      if (emit && advance) begin
        if (pend_valid) begin
          out_r <= pend;
        end
        pend.site      <= site_cur;
        pend.zero_mask <= zm;
        pend.one_mask  <= om;
        pend.last      <= 1'b0;
        pend_valid     <= 1'b1;
      end

      // end of site: commit the new order bank and site count
      if ((state == ST_CLOSE) && advance) begin
        site_count <= site_cur + SITE_BITS'(1);
        rbank      <= ~rbank;
        nz_saved   <= nz_cnt;
        fresh      <= 1'b0;
      end

      // the remaining pending report is the final one of this site
      if (flush && advance) begin
        out_r      <= '{site: pend.site, zero_mask: pend.zero_mask,
                        one_mask: pend.one_mask, last: 1'b1};
        pend_valid <= 1'b0;
      end
    end
  end

  assign site       = 16'(out_r.site);
  assign zero_group = 64'(out_r.zero_mask);
  assign one_group  = 64'(out_r.one_mask);
  assign last       = out_r.last;

endmodule

// ===== test/pbwt_long_match_reporter_tb.sv =====
// ----------------------------------------------------------------------------
// pbwt_long_match_reporter_tb
// drives site columns through the long match reporter and checks every
// reported group against a positional bwt predictor kept in a scoreboard
// ----------------------------------------------------------------------------
module pbwt_long_match_reporter_tb;
  import pbwt_pkg::*;

  localparam int MAX_REPORTS  = 32;
  // drain wait covers a walk over all entries and its closing states
  localparam int DRAIN_CYCLES = HAPLOTYPES + 8;
  localparam int HOLD_CYCLES  = 600;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 62;

  // predictor of the sorted order, divergence and reported groups
  class match_block_scoreboard;
    logic [HAP_BITS-1:0]  hap_order [HAPLOTYPES];
    logic [SITE_BITS-1:0] hap_div   [HAPLOTYPES];
    logic [SITE_BITS-1:0] site_idx;
    logic [15:0]          min_len;
    result_t              pending_reports[$];
    int                   mismatches;

    function new();
      min_len    = MML_RESET;
      mismatches = 0;
      clear_panel();
    endfunction

    function void clear_panel();
      for (int i = 0; i < HAPLOTYPES; i++) begin
        hap_order[i] = HAP_BITS'(i);
        hap_div[i]   = '0;
      end
      site_idx = '0;
    endfunction

    // accepted column: walk in sorted order, close groups, then partition
    function void note_site(logic [63:0] col, logic rs);
      logic [HAP_BITS-1:0]  zero_ord [HAPLOTYPES];
      logic [HAP_BITS-1:0]  one_ord  [HAPLOTYPES];
      logic [SITE_BITS-1:0] zero_dv  [HAPLOTYPES];
      logic [SITE_BITS-1:0] one_dv   [HAPLOTYPES];
      logic [HAP_BITS-1:0]  h;
      logic [63:0]          zm, om;
      longint               thr, p, q, m;
      int                   nz, n_one;
      result_t              batch[$];
      result_t              rep;
      if (rs) clear_panel();
      // site range used up: column ignored
      if (site_idx == SITE_END) return;
      nz    = 0;
      n_one = 0;
      zm    = '0;
      om    = '0;
      thr   = longint'(site_idx) - longint'(min_len);
      p     = longint'(site_idx) + 1;
      q     = p;
      for (int i = 0; i < HAPLOTYPES; i++) begin
        h = hap_order[i];
        m = longint'(hap_div[i]);
        if (m > thr) begin
          if (zm != 0 && om != 0 && batch.size() < MAX_REPORTS) begin
            rep   = '{site: site_idx, zero_mask: zm, one_mask: om, last: 1'b0};
            batch = {batch, rep};
          end
          zm = '0;
          om = '0;
        end
        if (m > p) p = m;
        if (m > q) q = m;
        if (!col[h]) begin
          zero_ord[nz] = h;
          zero_dv[nz]  = p[SITE_BITS-1:0];
          nz++;
          p     = 0;
          zm[h] = 1'b1;
        end else begin
          one_ord[n_one] = h;
          one_dv[n_one]  = q[SITE_BITS-1:0];
          n_one++;
          q     = 0;
          om[h] = 1'b1;
        end
      end
      if (zm != 0 && om != 0 && batch.size() < MAX_REPORTS) begin
        rep   = '{site: site_idx, zero_mask: zm, one_mask: om, last: 1'b0};
        batch = {batch, rep};
      end
      for (int i = 0; i < nz; i++) begin
        hap_order[i] = zero_ord[i];
        hap_div[i]   = zero_dv[i];
      end
      for (int i = 0; i < n_one; i++) begin
        hap_order[nz + i] = one_ord[i];
        hap_div[nz + i]   = one_dv[i];
      end
      site_idx = site_idx + 1'b1;
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) pending_reports = {pending_reports, batch[i]};
    endfunction

    function void check_report(logic [15:0] s, logic [63:0] zg, logic [63:0] og,
                               logic lst);
      result_t exp_rep;
      if (pending_reports.size() == 0) begin
        $error("report with nothing expected: site %0d zero %h one %h", s, zg, og);
        mismatches++;
        return;
      end
      exp_rep = pending_reports.pop_front();
      if (s !== exp_rep.site) begin
        $error("site: expected %0d, got %0d", exp_rep.site, s);
        mismatches++;
      end
      if (zg !== exp_rep.zero_mask) begin
        $error("zero_group: expected %h, got %h", exp_rep.zero_mask, zg);
        mismatches++;
      end
      if (og !== exp_rep.one_mask) begin
        $error("one_group: expected %h, got %h", exp_rep.one_mask, og);
        mismatches++;
      end
      if (lst !== exp_rep.last) begin
        $error("last: expected %0d, got %0d", exp_rep.last, lst);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] alleles;
  logic        restart;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] site;
  logic [63:0] zero_group;
  logic [63:0] one_group;
  logic        last;

  match_block_scoreboard sb;

  // random idling on each side, switched off for one whole phase
  bit sender_idling   = 1'b1;
  bit receiver_idling = 1'b1;
  // asks the receiver process for one long hold-off
  bit hold_req        = 1'b0;
  // cycles since the last accepted item on either side
  int quiet_cycles    = 0;

  pbwt_long_match_reporter dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .alleles    (alleles),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .site       (site),
    .zero_group (zero_group),
    .one_group  (one_group),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random back-pressure, plus a long hold-off counted here
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= !receiver_idling || ($urandom_range(99) >= 21);
      end
    end
  end

  // monitor: both handshakes sampled at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && in_ready) sb.note_site(alleles, restart);
      if (out_valid && out_ready) sb.check_report(site, zero_group, one_group, last);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog: nothing moving for too long ends the run
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // offer one column; entered and left at a falling edge, valid held high
  task automatic send_site(input logic [63:0] col, input logic rs);
    while (sender_idling && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    alleles  <= col;
    restart  <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering, wait for every expected report, then let the walk finish
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_min_length(input logic [15:0] len);
    cfg_write <= 1'b1;
    cfg_data  <= len;
    sb.min_len = len;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // panels of related haplotypes: each haplotype follows one of a few founders
  // with rare flips, so long shared blocks build up; some columns are noise
  // and some panels start without a restart or get one midway
  task automatic run_columns(input int count);
    int          sent;
    int          span;
    int          nclus;
    int          cluster_of [HAPLOTYPES];
    logic [7:0]  founder_bits;
    logic [63:0] col;
    logic        rs;
    sent = 0;
    while (sent < count) begin
      span  = ($urandom_range(9) == 0) ? $urandom_range(60, 120) : $urandom_range(8, 40);
      nclus = $urandom_range(2, 8);
      foreach (cluster_of[h]) cluster_of[h] = $urandom_range(nclus - 1);
      for (int s = 0; s < span && sent < count; s++) begin
        if (s == 0) rs = ($urandom_range(9) != 0);
        else rs = ($urandom_range(49) == 0);
        if ($urandom_range(99) < 15) begin
          col = {$urandom, $urandom};
        end else begin
          founder_bits = 8'($urandom);
          for (int h = 0; h < HAPLOTYPES; h++)
            col[h] = founder_bits[cluster_of[h]] ^ ($urandom_range(99) < 3);
        end
        send_site(col, rs);
        sent++;
      end
    end
  endtask

  initial begin
    logic [15:0] settings [8];
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    alleles   = '0;
    restart   = 1'b0;
    sb        = new();
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed columns with the reset match length
    // single allele everywhere in the first two columns, so no group holds both there
    send_site(64'h0000_0000_0000_0000, 1'b0);
    send_site(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_site(64'h5555_5555_5555_5555, 1'b0);
    send_site(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_site(64'h0000_0000_FFFF_FFFF, 1'b0);
    send_site(64'hFFFF_FFFF_0000_0000, 1'b0);
    send_site(64'h0000_0000_0000_0001, 1'b0);
    send_site(64'h8000_0000_0000_0000, 1'b0);
    send_site(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
    // restart mid panel, then a repeating pattern to grow long blocks
    send_site(64'h0F0F_0F0F_0F0F_0F0F, 1'b1);
    send_site(64'h00FF_00FF_00FF_00FF, 1'b0);
    send_site(64'h3333_3333_3333_3333, 1'b0);
    send_site(64'h5555_5555_5555_5555, 1'b0);
    send_site(64'h0F0F_0F0F_0F0F_0F0F, 1'b0);
    send_site(64'h00FF_00FF_00FF_00FF, 1'b0);
    send_site(64'h3333_3333_3333_3333, 1'b0);
    send_site(64'h5555_5555_5555_5555, 1'b0);
    send_site(64'h0F0F_0F0F_0F0F_0F0F, 1'b0);
    send_site(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_site(64'h0000_FFFF_0000_FFFF, 1'b0);

    // match length settings: one, zero, longest, and a few between
    settings = '{16'd1, 16'd0, 16'hFFFF, 16'd8, 16'($urandom_range(5, 12)),
                 16'd2, 16'd4, 16'd16};
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      write_min_length(settings[ph]);
      sender_idling   = (ph != 3);
      receiver_idling = (ph != 3);
      if (ph == 1) begin
        // receiver holds off while columns keep coming, so the block fills up
        run_columns(10);
        hold_req = 1'b1;
        run_columns(PHASE_ITEMS - 10);
      end else if (ph == 5) begin
        // sender pauses until every report is out
        run_columns(30);
        wait_drained();
        run_columns(PHASE_ITEMS - 30);
      end else begin
        run_columns(PHASE_ITEMS);
      end
    end
    sender_idling   = 1'b1;
    receiver_idling = 1'b1;

    wait_drained();
    if (sb.pending_reports.size() != 0) begin
      $error("%0d reports never arrived", sb.pending_reports.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
